// File: src/vmnet_pkg.sv
// Shared constants for the virtio-mmio network register block.
package vmnet_pkg;

  localparam int unsigned MaxQueueEntries = 1024;
  localparam int unsigned QueueCount      = 2;
  localparam int unsigned ConfigWords     = 3;
  localparam int unsigned CfgIdxW         = $clog2(ConfigWords) > 0 ? $clog2(ConfigWords) : 1;
  localparam int unsigned QEntW           = $clog2(MaxQueueEntries + 1);

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // operation codes (tuser)
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_USED  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // access size codes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_HALF  = 2'd1;
  localparam logic [1:0] SZ_WORD  = 2'd2;
  localparam logic [1:0] SZ_OTHER = 2'd3;

  // fault codes
  localparam logic [1:0] FLT_NONE    = 2'd0;
  localparam logic [1:0] FLT_ACCESS  = 2'd1;
  localparam logic [1:0] FLT_MISALGN = 2'd2;
  localparam logic [1:0] FLT_ILLEGAL = 2'd3;

  // queue kick codes
  localparam logic [1:0] KICK_NONE = 2'd0;
  localparam logic [1:0] KICK_RX   = 2'd1;
  localparam logic [1:0] KICK_TX   = 2'd2;

  // configuration register indexes
  localparam logic CFG_VENDOR_ID = 1'b0;
  localparam logic CFG_RAM_LIMIT = 1'b1;

  // register word indexes
  localparam logic [7:0] REG_MAGIC       = 8'd0;
  localparam logic [7:0] REG_VERSION     = 8'd1;
  localparam logic [7:0] REG_DEVICE_ID   = 8'd2;
  localparam logic [7:0] REG_VENDOR_ID   = 8'd3;
  localparam logic [7:0] REG_DEV_FEAT    = 8'd4;
  localparam logic [7:0] REG_DEV_FEAT_SEL = 8'd5;
  localparam logic [7:0] REG_DRV_FEAT    = 8'd8;
  localparam logic [7:0] REG_DRV_FEAT_SEL = 8'd9;
  localparam logic [7:0] REG_QUEUE_SEL   = 8'd12;
  localparam logic [7:0] REG_QUEUE_MAX   = 8'd13;
  localparam logic [7:0] REG_QUEUE_SIZE  = 8'd14;
  localparam logic [7:0] REG_QUEUE_READY = 8'd17;
  localparam logic [7:0] REG_QUEUE_NOTIFY = 8'd20;
  localparam logic [7:0] REG_IRQ_STATUS  = 8'd24;
  localparam logic [7:0] REG_IRQ_ACK     = 8'd25;
  localparam logic [7:0] REG_STATUS      = 8'd28;
  localparam logic [7:0] REG_DESC_LO     = 8'd32;
  localparam logic [7:0] REG_DESC_HI     = 8'd33;
  localparam logic [7:0] REG_AVAIL_LO    = 8'd36;
  localparam logic [7:0] REG_AVAIL_HI    = 8'd37;
  localparam logic [7:0] REG_USED_LO     = 8'd40;
  localparam logic [7:0] REG_USED_HI     = 8'd41;
  localparam logic [7:0] REG_CFG_GEN     = 8'd63;
  localparam logic [7:0] REG_CFG_BASE    = 8'd64;

  localparam logic [31:0] MAGIC_WORD     = 32'h7472_6976;
  localparam logic [31:0] VERSION_VAL    = 32'd2;
  localparam logic [31:0] DEVICE_ID_VAL  = 32'd1;
  localparam logic [7:0]  ST_DRIVER_OK   = 8'h04;
  localparam logic [7:0]  ST_NEEDS_RESET = 8'h40;
  localparam logic [1:0]  IRQ_USED       = 2'b01;
  localparam logic [1:0]  IRQ_CONF       = 2'b10;

  localparam logic [31:0] VENDOR_ID_RST = 32'h1234_5678;
  localparam logic [31:0] RAM_LIMIT_RST = 32'h2000_0000;

endpackage

// File: src/virtio_mmio_net_register_block_unit.sv
// Virtio-MMIO v2 network device register file with a registered result stage.
// The result of an accepted transaction is registered and appears in the output register in the next cycle.
// Throughput: one transaction per cycle; tready stays high while the result is taken
// or the output register is empty.
// Reset: all device state, the config words and the output valid clear at once;
// vendor id and RAM limit return to their defaults.
module virtio_mmio_net_register_block_unit
  import vmnet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: word_address[7:0], access_size[9:8], write_data[41:10], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]          s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: read_data[31:0], fault[33:32], queue_kick[35:34], interrupt_line[36], zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [31:0] vendor_id_q, ram_limit_q;

  logic [7:0]  status_q, status_d;
  logic [1:0]  pend_q, pend_d;
  logic [31:0] dev_page_q, dev_page_d;
  logic [31:0] drv_page_q, drv_page_d;
  logic [31:0] drv_bits_q, drv_bits_d;
  logic        qsel_q, qsel_d;
  logic [QEntW-1:0] qent_q [QueueCount], qent_d [QueueCount];
  logic        qen_q [QueueCount], qen_d [QueueCount];
  logic [29:0] desc_q [QueueCount], desc_d [QueueCount];
  logic [29:0] avail_q [QueueCount], avail_d [QueueCount];
  logic [29:0] used_q [QueueCount], used_d [QueueCount];
  logic [31:0] cfgw_q [ConfigWords], cfgw_d [ConfigWords];

  logic        out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic        s_accept;
  logic [1:0]  op;
  logic [7:0]  addr;
  logic [1:0]  size;
  logic [31:0] wdata;

  logic [31:0] rdata;
  logic [1:0]  fault, kick;
  logic        err;
  logic        in_cfg;
  logic [CfgIdxW-1:0] cfg_idx;
  logic        ring_ok;
  logic [29:0] ring_val;
  logic [7:0]  cfg_off;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign op    = s_axis_tuser;
  assign addr  = s_axis_tdata[7:0];
  assign size  = s_axis_tdata[9:8];
  assign wdata = s_axis_tdata[41:10];

  assign cfg_off = addr - REG_CFG_BASE;
  assign in_cfg  = (addr >= REG_CFG_BASE) && (cfg_off < 8'(ConfigWords));
  assign cfg_idx = cfg_off[CfgIdxW-1:0];

  // ring base low word: byte address must be word aligned and below the RAM limit
  assign ring_ok  = (wdata < ram_limit_q) && (wdata[1:0] == 2'b00);
  assign ring_val = ring_ok ? wdata[31:2] : 30'd0;

  always_comb begin
    status_d   = status_q;
    pend_d     = pend_q;
    dev_page_d = dev_page_q;
    drv_page_d = drv_page_q;
    drv_bits_d = drv_bits_q;
    qsel_d     = qsel_q;
    qent_d     = qent_q;
    qen_d      = qen_q;
    desc_d     = desc_q;
    avail_d    = avail_q;
    used_d     = used_q;
    cfgw_d     = cfgw_q;
    rdata      = 32'd0;
    fault      = FLT_NONE;
    kick       = KICK_NONE;
    err        = 1'b0;

    if (s_accept) begin
      case (op)
        OP_USED: pend_d = pend_q | IRQ_USED;
        OP_READ, OP_WRITE: begin
          if (size == SZ_BYTE || size == SZ_HALF) begin
            fault = FLT_MISALGN;
          end else if (size == SZ_OTHER) begin
            fault = FLT_ILLEGAL;
          end else if (op == OP_READ) begin
            case (addr)
              REG_MAGIC:       rdata = MAGIC_WORD;
              REG_VERSION:     rdata = VERSION_VAL;
              REG_DEVICE_ID:   rdata = DEVICE_ID_VAL;
              REG_VENDOR_ID:   rdata = vendor_id_q;
              REG_DEV_FEAT:    rdata = {31'd0, dev_page_q == 32'd1};
              REG_QUEUE_MAX:   rdata = 32'(MaxQueueEntries);
              REG_QUEUE_READY: rdata = {31'd0, qen_q[qsel_q]};
              REG_IRQ_STATUS:  rdata = {30'd0, pend_q};
              REG_STATUS:      rdata = {24'd0, status_q};
              REG_CFG_GEN:     rdata = 32'd0;
              default: begin
                if (in_cfg) rdata = cfgw_q[cfg_idx];
                else        fault = FLT_ACCESS;
              end
            endcase
          end else begin
            case (addr)
              REG_DEV_FEAT_SEL: dev_page_d = wdata;
              REG_DRV_FEAT: begin
                if (drv_page_q == 32'd0) drv_bits_d = wdata;
              end
              REG_DRV_FEAT_SEL: drv_page_d = wdata;
              REG_QUEUE_SEL: begin
                if (wdata < 32'(QueueCount)) qsel_d = wdata[0];
                else                         err = 1'b1;
              end
              REG_QUEUE_SIZE: begin
                if (wdata != 32'd0 && wdata <= 32'(MaxQueueEntries))
                  qent_d[qsel_q] = wdata[QEntW-1:0];
                else
                  err = 1'b1;
              end
              REG_QUEUE_READY: qen_d[qsel_q] = wdata[0];
              REG_QUEUE_NOTIFY: begin
                if (wdata < 32'(QueueCount)) kick = wdata[0] ? KICK_TX : KICK_RX;
                else                         err = 1'b1;
              end
              REG_IRQ_ACK: pend_d = pend_q & ~wdata[1:0];
              REG_STATUS: begin
                if (wdata == 32'd0) begin
                  // device reset: everything but the config words
                  status_d   = 8'd0;
                  pend_d     = 2'd0;
                  dev_page_d = 32'd0;
                  drv_page_d = 32'd0;
                  drv_bits_d = 32'd0;
                  qsel_d     = 1'b0;
                  for (int i = 0; i < QueueCount; i++) begin
                    qent_d[i]  = '0;
                    qen_d[i]   = 1'b0;
                    desc_d[i]  = 30'd0;
                    avail_d[i] = 30'd0;
                    used_d[i]  = 30'd0;
                  end
                end else begin
                  status_d = status_q | wdata[7:0];
                end
              end
              REG_DESC_LO: begin
                desc_d[qsel_q] = ring_val;
                err = !ring_ok;
              end
              REG_AVAIL_LO: begin
                avail_d[qsel_q] = ring_val;
                err = !ring_ok;
              end
              REG_USED_LO: begin
                used_d[qsel_q] = ring_val;
                err = !ring_ok;
              end
              REG_DESC_HI, REG_AVAIL_HI, REG_USED_HI: err = (wdata != 32'd0);
              default: begin
                if (in_cfg) cfgw_d[cfg_idx] = wdata;
                else        fault = FLT_ACCESS;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    // status writes never raise an error, so status_q is the status seen here
    if (err) begin
      status_d = status_q | ST_NEEDS_RESET;
      if ((status_q & ST_DRIVER_OK) != 8'd0) pend_d = pend_q | IRQ_CONF;
    end

    out_data_d = {3'd0, pend_d != 2'd0, kick, fault, rdata};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_id_q <= VENDOR_ID_RST;
      ram_limit_q <= RAM_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VENDOR_ID: vendor_id_q <= cfg_wdata_i;
        CFG_RAM_LIMIT: ram_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= 8'd0;
      pend_q     <= 2'd0;
      dev_page_q <= 32'd0;
      drv_page_q <= 32'd0;
      drv_bits_q <= 32'd0;
      qsel_q     <= 1'b0;
      for (int i = 0; i < QueueCount; i++) begin
        qent_q[i]  <= '0;
        qen_q[i]   <= 1'b0;
        desc_q[i]  <= 30'd0;
        avail_q[i] <= 30'd0;
        used_q[i]  <= 30'd0;
      end
      for (int i = 0; i < ConfigWords; i++) cfgw_q[i] <= 32'd0;
    end else begin
      status_q   <= status_d;
      pend_q     <= pend_d;
      dev_page_q <= dev_page_d;
      drv_page_q <= drv_page_d;
      drv_bits_q <= drv_bits_d;
      qsel_q     <= qsel_d;
      qent_q     <= qent_d;
      qen_q      <= qen_d;
      desc_q     <= desc_d;
      avail_q    <= avail_d;
      used_q     <= used_d;
      cfgw_q     <= cfgw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a kick only comes from a good notify write
  a_kick_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[35:34] != KICK_NONE) |-> m_axis_tdata[33:32] == FLT_NONE)
    else $error("queue kick together with a fault");

  // read data only on a good read
  a_rdata_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[31:0] != 32'd0) |-> m_axis_tdata[33:32] == FLT_NONE)
    else $error("read data returned with a fault");

  // interrupt line of a fresh result follows the interrupt status it leaves behind
  a_irq_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_axis_tdata[36] == (pend_q != 2'd0))
    else $error("interrupt line disagrees with interrupt status");

  // a bad queue select sets NEEDS_RESET
  a_bad_qsel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && op == OP_WRITE && size == SZ_WORD && addr == REG_QUEUE_SEL
      && wdata >= 32'(QueueCount) |=> (status_q & ST_NEEDS_RESET) != 8'd0)
    else $error("bad queue select did not set NEEDS_RESET");

endmodule

// File: bench/vmnet_reg_checker.sv
// Checker for the virtio-mmio net register block: predicts each access result and compares.
module vmnet_reg_checker
  import vmnet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // tdata: word_address[7:0], access_size[9:8], write_data[41:10], zero fill
  input  logic [InDataW-1:0]  s_tdata_i,
  // tuser: operation[1:0]
  input  logic [1:0]          s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // tdata: read_data[31:0], fault[33:32], queue_kick[35:34], interrupt_line[36], zero fill
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  outstanding_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // highest field first, so the layout matches the result tdata
  typedef struct packed {
    logic        irq_line;
    logic [1:0]  queue_kick;
    logic [1:0]  fault;
    logic [31:0] read_data;
  } access_result_t;

  access_result_t expected_results[$];
  int failures = 0;
  int pending_count = 0;

  // device registers as the bus sees them
  logic [31:0] vendor_id;
  logic [31:0] ram_limit;
  logic [31:0] dev_feat_page;
  logic [7:0]  dev_status;
  logic [1:0]  pending_irq;
  logic        sel_queue;
  logic        queue_ready [QueueCount];
  logic [31:0] cfg_words [ConfigWords];

  assign fail_count_o  = failures;
  assign outstanding_o = pending_count;

  // config space survives a status-zero write, everything else goes
  function automatic void clear_device();
    dev_status    = '0;
    pending_irq   = '0;
    dev_feat_page = '0;
    sel_queue     = 1'b0;
    foreach (queue_ready[i]) queue_ready[i] = 1'b0;
  endfunction

  function automatic void raise_error();
    dev_status |= ST_NEEDS_RESET;
    if ((dev_status & ST_DRIVER_OK) != '0) pending_irq |= IRQ_CONF;
  endfunction

  function automatic bit in_cfg_window(input logic [7:0] addr);
    return (addr >= REG_CFG_BASE) && (addr < REG_CFG_BASE + ConfigWords);
  endfunction

  function automatic access_result_t apply_access(input logic [1:0] op,
      input logic [7:0] addr, input logic [1:0] size, input logic [31:0] data);
    access_result_t r;
    bit known;
    r = '0;
    known = 1'b1;
    if (op == OP_USED) begin
      pending_irq |= IRQ_USED;
    end else if (op == OP_READ || op == OP_WRITE) begin
      if (size == SZ_BYTE || size == SZ_HALF) begin
        r.fault = FLT_MISALGN;
      end else if (size == SZ_OTHER) begin
        r.fault = FLT_ILLEGAL;
      end else if (op == OP_READ) begin
        case (addr)
          REG_MAGIC:       r.read_data = MAGIC_WORD;
          REG_VERSION:     r.read_data = VERSION_VAL;
          REG_DEVICE_ID:   r.read_data = DEVICE_ID_VAL;
          REG_VENDOR_ID:   r.read_data = vendor_id;
          REG_DEV_FEAT:    r.read_data = (dev_feat_page == 32'd1) ? 32'd1 : 32'd0;
          REG_QUEUE_MAX:   r.read_data = MaxQueueEntries;
          REG_QUEUE_READY: r.read_data = {31'b0, queue_ready[sel_queue]};
          REG_IRQ_STATUS:  r.read_data = {30'b0, pending_irq};
          REG_STATUS:      r.read_data = {24'b0, dev_status};
          REG_CFG_GEN:     r.read_data = '0;
          default: begin
            if (in_cfg_window(addr)) r.read_data = cfg_words[addr - REG_CFG_BASE];
            else known = 1'b0;
          end
        endcase
      end else begin
        case (addr)
          REG_DEV_FEAT_SEL: dev_feat_page = data;
          // driver feature bits are never readable, only the access itself counts
          REG_DRV_FEAT, REG_DRV_FEAT_SEL: ;
          REG_QUEUE_SEL: begin
            if (data < QueueCount) sel_queue = data[0];
            else raise_error();
          end
          REG_QUEUE_SIZE: begin
            if (data == '0 || data > MaxQueueEntries) raise_error();
          end
          REG_QUEUE_READY: queue_ready[sel_queue] = data[0];
          REG_QUEUE_NOTIFY: begin
            if (data < QueueCount) r.queue_kick = data[0] ? KICK_TX : KICK_RX;
            else raise_error();
          end
          REG_IRQ_ACK: pending_irq &= ~data[1:0];
          REG_STATUS: begin
            dev_status |= data[7:0];
            if (data == '0) clear_device();
          end
          REG_DESC_LO, REG_AVAIL_LO, REG_USED_LO: begin
            if (data >= ram_limit || data[1:0] != 2'b00) raise_error();
          end
          REG_DESC_HI, REG_AVAIL_HI, REG_USED_HI: begin
            if (data != '0) raise_error();
          end
          default: begin
            if (in_cfg_window(addr)) cfg_words[addr - REG_CFG_BASE] = data;
            else known = 1'b0;
          end
        endcase
      end
      if (!known) r.fault = FLT_ACCESS;
    end
    r.irq_line = |pending_irq;
    return r;
  endfunction

  function automatic bit field_differs(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    access_result_t want;
    access_result_t got;
    bit bad;
    if (!rst_ni) begin
      vendor_id = VENDOR_ID_RST;
      ram_limit = RAM_LIMIT_RST;
      clear_device();
      foreach (cfg_words[i]) cfg_words[i] = '0;
      expected_results.delete();
      pending_count = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_VENDOR_ID) vendor_id = cfg_wdata_i;
        else if (cfg_index_i == CFG_RAM_LIMIT) ram_limit = cfg_wdata_i;
      end
      // push first: the front is always the older transaction
      if (s_tvalid_i && s_tready_i) begin
        expected_results.push_back(apply_access(s_tuser_i, s_tdata_i[7:0],
                                                s_tdata_i[9:8], s_tdata_i[41:10]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[36:0];
        if (expected_results.size() == 0) begin
          $display("%0t ns: result %h with no access outstanding", $time, m_tdata_i);
          failures++;
        end else begin
          want = expected_results.pop_front();
          bad = field_differs("read_data", want.read_data, got.read_data)
              | field_differs("fault", 32'(want.fault), 32'(got.fault))
              | field_differs("queue_kick", 32'(want.queue_kick), 32'(got.queue_kick))
              | field_differs("interrupt_line", 32'(want.irq_line), 32'(got.irq_line));
          if (bad) failures++;
        end
      end
      pending_count = expected_results.size();
    end
  end

endmodule

// File: bench/tb_virtio_mmio_net_register_block_unit.sv
// Testbench top for the virtio-mmio net register block: clock, reset, stimulus and verdict.
module tb_virtio_mmio_net_register_block_unit;
  import vmnet_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseItems = 300;
  localparam int PhaseCount = 6;
  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = CFG_VENDOR_ID;
  logic [31:0]         cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = OP_NONE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int failures;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  logic [31:0] cur_limit = RAM_LIMIT_RST;

  virtio_mmio_net_register_block_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vmnet_reg_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .outstanding_o (outstanding),
    .fail_count_o  (failures)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("virtio_mmio_net_register_block_unit: mismatch");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_access(input logic [1:0] op, input logic [7:0] addr,
      input logic [1:0] size, input logic [31:0] data);
    int gap;
    @(negedge clk_i);
    gap = 0;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InDataW - 42){1'b0}}, data, size, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] vid, input logic [31:0] limit);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_VENDOR_ID;
    cfg_wdata_i <= vid;
    @(negedge clk_i);
    cfg_index_i <= CFG_RAM_LIMIT;
    cfg_wdata_i <= limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_limit = limit;
  endtask

  function automatic logic [7:0] pick_address();
    logic [7:0] a;
    case ($urandom_range(0, 26))
      0:  a = REG_MAGIC;
      1:  a = REG_VERSION;
      2:  a = REG_DEVICE_ID;
      3:  a = REG_VENDOR_ID;
      4:  a = REG_DEV_FEAT;
      5:  a = REG_DEV_FEAT_SEL;
      6:  a = REG_DRV_FEAT;
      7:  a = REG_DRV_FEAT_SEL;
      8:  a = REG_QUEUE_SEL;
      9:  a = REG_QUEUE_MAX;
      10: a = REG_QUEUE_SIZE;
      11: a = REG_QUEUE_READY;
      12: a = REG_QUEUE_NOTIFY;
      13: a = REG_IRQ_STATUS;
      14: a = REG_IRQ_ACK;
      15: a = REG_STATUS;
      16: a = REG_DESC_LO;
      17: a = REG_DESC_HI;
      18: a = REG_AVAIL_LO;
      19: a = REG_AVAIL_HI;
      20: a = REG_USED_LO;
      21: a = REG_USED_HI;
      22: a = REG_CFG_GEN;
      // config window plus the word just past it
      default: a = REG_CFG_BASE + 8'($urandom_range(0, ConfigWords));
    endcase
    return a;
  endfunction

  task automatic push_random();
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [1:0]  size;
    logic [31:0] data;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) op = OP_USED;
    else if (roll < 9) op = OP_NONE;
    else if (roll < 50) op = OP_READ;
    else op = OP_WRITE;
    size = ($urandom_range(0, 99) < 88) ? SZ_WORD : 2'($urandom_range(0, 3));
    addr = ($urandom_range(0, 99) < 85) ? pick_address() : 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    case (addr)
      REG_QUEUE_SEL, REG_QUEUE_NOTIFY, REG_DEV_FEAT_SEL, REG_DRV_FEAT_SEL:
        data = (roll < 80) ? $urandom_range(0, 2) : $urandom;
      REG_QUEUE_SIZE:
        data = (roll < 80) ? $urandom_range(0, MaxQueueEntries + 2) : $urandom;
      REG_QUEUE_READY, REG_IRQ_ACK:
        data = (roll < 80) ? $urandom_range(0, 3) : $urandom;
      REG_STATUS: begin
        if (roll < 25) data = '0;
        else if (roll < 85) data = $urandom_range(1, 255);
        else data = $urandom;
      end
      REG_DESC_LO, REG_AVAIL_LO, REG_USED_LO: begin
        case ($urandom_range(0, 3))
          0: data = $urandom_range(0, 4095) & ~32'd3;
          1: data = cur_limit & ~32'd3;
          2: data = cur_limit - $urandom_range(1, 4);
          default: data = $urandom;
        endcase
      end
      REG_DESC_HI, REG_AVAIL_HI, REG_USED_HI:
        data = (roll < 70) ? '0 : $urandom;
      default: data = $urandom;
    endcase
    push_access(op, addr, size, data);
  endtask

  initial begin : stimulus
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    push_access(OP_READ,  REG_MAGIC,        SZ_WORD,  '0);
    push_access(OP_READ,  REG_VENDOR_ID,    SZ_WORD,  '0);
    push_access(OP_WRITE, REG_DEV_FEAT_SEL, SZ_WORD,  32'd1);
    push_access(OP_READ,  REG_DEV_FEAT,     SZ_WORD,  '0);
    push_access(OP_READ,  REG_QUEUE_MAX,    SZ_BYTE,  '0);
    push_access(OP_READ,  REG_QUEUE_MAX,    SZ_HALF,  '0);
    push_access(OP_WRITE, REG_STATUS,       SZ_OTHER, 32'hFFFF_FFFF);
    push_access(OP_READ,  8'hFF,            SZ_WORD,  '0);
    push_access(OP_WRITE, REG_MAGIC,        SZ_WORD,  32'hFFFF_FFFF);
    push_access(OP_READ,  REG_QUEUE_SEL,    SZ_WORD,  '0);
    push_access(OP_WRITE, REG_STATUS,       SZ_WORD,  32'h0000_000F);
    // queue select out of range with DRIVER_OK set raises the config interrupt
    push_access(OP_WRITE, REG_QUEUE_SEL,    SZ_WORD,  32'd2);
    push_access(OP_READ,  REG_IRQ_STATUS,   SZ_WORD,  '0);
    push_access(OP_WRITE, REG_QUEUE_SIZE,   SZ_WORD,  '0);
    push_access(OP_WRITE, REG_QUEUE_NOTIFY, SZ_WORD,  32'd1);
    push_access(OP_WRITE, REG_QUEUE_NOTIFY, SZ_WORD,  32'd0);
    push_access(OP_USED,  8'hFF,            SZ_BYTE,  32'hFFFF_FFFF);
    push_access(OP_WRITE, REG_IRQ_ACK,      SZ_WORD,  32'hFFFF_FFFF);
    push_access(OP_WRITE, REG_DESC_LO,      SZ_WORD,  RAM_LIMIT_RST);
    push_access(OP_WRITE, REG_AVAIL_HI,     SZ_WORD,  32'd1);
    push_access(OP_WRITE, REG_QUEUE_READY,  SZ_WORD,  32'd1);
    push_access(OP_READ,  REG_QUEUE_READY,  SZ_WORD,  '0);
    push_access(OP_WRITE, REG_CFG_BASE + 8'd2, SZ_WORD, 32'hFFFF_FFFF);
    push_access(OP_READ,  REG_CFG_BASE + 8'd2, SZ_WORD, '0);
    push_access(OP_NONE,  8'hFF,            SZ_OTHER, 32'hFFFF_FFFF);
    // all-zero status write clears the device but not the config words
    push_access(OP_WRITE, REG_STATUS,       SZ_WORD,  '0);
    push_access(OP_READ,  REG_STATUS,       SZ_WORD,  '0);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          set_config('0, 32'd4);
          tx_idle_pct = 20;
          rx_idle_pct = 20;
        end
        1: begin
          set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
          tx_idle_pct = 0;
          rx_idle_pct = 30;
          // sink holds off while the source keeps offering, so the block backs up
          hold_req = 1'b1;
        end
        2: begin
          set_config(VENDOR_ID_RST, RAM_LIMIT_RST);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        3: begin
          set_config($urandom, $urandom_range(4, 32'hFFFF_FFFF));
          tx_idle_pct = 40;
          rx_idle_pct = 40;
        end
        4: begin
          set_config($urandom, $urandom_range(4, 4096));
          tx_idle_pct = 10;
          rx_idle_pct = 60;
        end
        default: begin
          set_config($urandom, $urandom_range(4, 32'hFFFF_FFFF));
          tx_idle_pct = 60;
          rx_idle_pct = 10;
        end
      endcase
      repeat (PhaseItems) push_random();
    end

    settle_idle();
    if (failures == 0) begin
      $display("virtio_mmio_net_register_block_unit: match");
    end else begin
      $display("virtio_mmio_net_register_block_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
src/vmnet_pkg.sv
src/virtio_mmio_net_register_block_unit.sv
bench/vmnet_reg_checker.sv
bench/tb_virtio_mmio_net_register_block_unit.sv
